### rtl/core/pcs_pkg.sv
package pcs_pkg;

  // field widths
  localparam int SLOT_W   = 8;
  localparam int PRIOR_W  = 16;
  localparam int VISITS_W = 20;
  localparam int MEAN_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int SCORE_W  = 32;

  // block constants
  localparam int VISIT_BITS   = 20;
  localparam int MAX_CHILDREN = 256;

  // fixed point alignment
  localparam int RAD_FRAC   = 16;  // parent visits scaled by 2^16 before the root
  localparam int FRAC_SHIFT = 20;  // product scaled down by 2^20 before the divide

  // derived datapath widths
  localparam int VIS_W   = (VISIT_BITS < VISITS_W) ? VISIT_BITS : VISITS_W;
  localparam int RAD_W   = VIS_W + RAD_FRAC;
  localparam int ROOT_W  = (RAD_W + 1) / 2;
  localparam int RADP_W  = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int W_W     = WEIGHT_W + PRIOR_W;
  localparam int NUM_W   = W_W + ROOT_W;
  localparam int Q_W     = NUM_W - FRAC_SHIFT;
  localparam int DEN_W   = VIS_W + 1;
  localparam int SC_W    = ((Q_W > SCORE_W) ? Q_W : SCORE_W) + 2;
  localparam int STEPS   = (Q_W > ROOT_W) ? Q_W : ROOT_W;
  localparam int STEP_W  = $clog2(STEPS);

  // stream packing
  localparam int IN_TDATA_W  = SLOT_W + PRIOR_W + 2 * VISITS_W + MEAN_W;
  localparam int OUT_TDATA_W = SLOT_W + SCORE_W;

  // configuration
  localparam int                  ADDR_W             = 3;
  localparam int                  APB_DATA_W         = 32;
  localparam logic                REG_EXPLORE_WEIGHT = 1'b0;
  localparam logic [WEIGHT_W-1:0] EXPLORE_RESET      = WEIGHT_W'(4096);

  typedef struct packed {
    logic load;       // capture an accepted child
    logic root_step;  // one digit of the square root
    logic mul;        // weight*prior times root, seeds divider
    logic div_step;   // one quotient bit
    logic pick;       // score, compare, and on a final child emit
  } pcs_cmd_t;

  typedef struct packed {
    logic final_item;
  } pcs_sts_t;

endpackage

### rtl/core/puct_child_selector.sv
// PUCT child selector.
// The children of one tree node arrive on the slave stream, one transfer per
// child; tlast marks the final child of a selection. Each child is scored as
// -2*mean + c_puct*prior*sqrt(parent_visits)/(1+visits) in fixed point and the
// running maximum is kept (first child always taken, ties go to the earlier
// child, slots at or above MAX_CHILDREN do not compete). After the final
// child one transfer on the master stream carries the winning slot and its
// saturated Q15.16 score; other children produce nothing.
// c_puct (Q4.12) lives in the APB register at byte address 0; write it only
// while the block is idle.
// Sequence: one child is worked on at a time. Each child passes from its
// acceptance through an accept state, 18 square root digits, a multiply,
// 30 quotient bits of the restoring divider and a pick step before the next
// child can be accepted. The result is registered in the output register at
// the pick step of the final child.
// Reset clears the running best, the output valid flag and sets c_puct to
// 1.0. If the receiver stalls, the result waits in the output register while
// further children are still taken; a later final child then holds in its
// pick cycle until the waiting result has been transferred.
module puct_child_selector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // APB configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pcs_pkg::ADDR_W-1:0]            paddr,
  input  logic [pcs_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [pcs_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  // child stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // child_slot, prior_prob, child_visits, mean_value, parent_visits
  input  logic [pcs_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  input  logic                                  s_axis_tlast,   // final_child
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // winner_slot, winner_score
  output logic [pcs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import pcs_pkg::*;

  localparam int PRIOR_LO  = SLOT_W;
  localparam int VISITS_LO = PRIOR_LO + PRIOR_W;
  localparam int MEAN_LO   = VISITS_LO + VISITS_W;
  localparam int PARENT_LO = MEAN_LO + MEAN_W;

  logic [WEIGHT_W-1:0]        explore_weight_q;
  logic                       reg_sel;
  pcs_cmd_t                   cmd;
  pcs_sts_t                   sts;
  logic [SLOT_W-1:0]          winner_slot;
  logic signed [SCORE_W-1:0]  winner_score;

  // register index from the word address
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_EXPLORE_WEIGHT) ? APB_DATA_W'(explore_weight_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      explore_weight_q <= EXPLORE_RESET;
    end else if (psel && penable && pwrite && pready
                 && (reg_sel == REG_EXPLORE_WEIGHT)) begin
      explore_weight_q <= pwdata[WEIGHT_W-1:0];
    end
  end

  pcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pcs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .explore_weight_i (explore_weight_q),
    .child_slot_i     (s_axis_tdata[SLOT_W-1:0]),
    .prior_prob_i     (s_axis_tdata[PRIOR_LO +: PRIOR_W]),
    .child_visits_i   (s_axis_tdata[VISITS_LO +: VISITS_W]),
    .mean_value_i     ($signed(s_axis_tdata[MEAN_LO +: MEAN_W])),
    .parent_visits_i  (s_axis_tdata[PARENT_LO +: VISITS_W]),
    .final_child_i    (s_axis_tlast),
    .winner_slot_o    (winner_slot),
    .winner_score_o   (winner_score)
  );

  assign m_axis_tdata = {winner_score, winner_slot};

endmodule

### rtl/core/pcs_ctrl.sv
module pcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  pcs_pkg::pcs_sts_t sts_i,
  output pcs_pkg::pcs_cmd_t cmd_o
);
  import pcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MUL,
    ST_DIV,
    ST_PICK
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] cnt_q;
  logic              out_valid_q;
  logic              out_blocked;

  // a final child must wait until the output register is free
  assign out_blocked = sts_i.final_item && out_valid_q && !m_ready_i;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.root_step = (state_q == ST_ROOT);
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.pick      = (state_q == ST_PICK) && !out_blocked;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.pick && sts_i.final_item) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (s_valid_i) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (cnt_q == STEP_W'(ROOT_W - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == STEP_W'(Q_W - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_PICK;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_PICK: begin
          if (!out_blocked) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // a pending result is never overwritten or dropped unseen
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_ready_i |=> out_valid_q)
    else $error("pending result lost");

  // results only appear from a final child's pick
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PICK && sts_i.final_item))
    else $error("result without final pick");

  // step counter stays inside the active iteration
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (cnt_q < STEP_W'(ROOT_W)))
    else $error("root counter overrun");

  a_cnt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < STEP_W'(Q_W)))
    else $error("divide counter overrun");

endmodule

### rtl/core/pcs_datapath.sv
module pcs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcs_pkg::pcs_cmd_t                   cmd_i,
  output pcs_pkg::pcs_sts_t                   sts_o,
  input  logic [pcs_pkg::WEIGHT_W-1:0]        explore_weight_i,
  input  logic [pcs_pkg::SLOT_W-1:0]          child_slot_i,
  input  logic [pcs_pkg::PRIOR_W-1:0]         prior_prob_i,
  input  logic [pcs_pkg::VISITS_W-1:0]        child_visits_i,
  input  logic signed [pcs_pkg::MEAN_W-1:0]   mean_value_i,
  input  logic [pcs_pkg::VISITS_W-1:0]        parent_visits_i,
  input  logic                                final_child_i,
  output logic [pcs_pkg::SLOT_W-1:0]          winner_slot_o,
  output logic signed [pcs_pkg::SCORE_W-1:0]  winner_score_o
);
  import pcs_pkg::*;

  localparam logic signed [SC_W-1:0] SAT_HI =
    {{(SC_W - SCORE_W + 1){1'b0}}, {(SCORE_W - 1){1'b1}}};
  localparam logic signed [SC_W-1:0] SAT_LO =
    {{(SC_W - SCORE_W + 1){1'b1}}, {(SCORE_W - 1){1'b0}}};

  // captured child
  logic [SLOT_W-1:0]        slot_q;
  logic                     slot_ok_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic                     final_q;
  logic [W_W-1:0]           w_q;
  logic [DEN_W-1:0]         den_q;

  // square root
  logic [RADP_W-1:0] rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_try;
  logic [REM_W-1:0]  root_trial;

  // divider, quotient shifts in where the dividend shifts out
  logic [Q_W-1:0]   dvd_q;
  logic [DEN_W-1:0] drem_q;
  logic [DEN_W:0]   div_try;
  logic [NUM_W-1:0] num;

  // running best
  logic                      have_q;
  logic [SLOT_W-1:0]         lead_slot_q;
  logic signed [SCORE_W-1:0] lead_score_q;
  logic [SLOT_W-1:0]         out_slot_q;
  logic signed [SCORE_W-1:0] out_score_q;

  logic signed [SC_W-1:0]    q_ext;
  logic signed [SC_W-1:0]    mean_ext;
  logic signed [SC_W-1:0]    sc_wide;
  logic signed [SCORE_W-1:0] score;
  logic                      take;
  logic [SLOT_W-1:0]         cand_slot;
  logic signed [SCORE_W-1:0] cand_score;

  assign rem_try    = {rem_q[ROOT_W-1:0], rad_q[RADP_W-1 -: 2]};
  assign root_trial = {root_q, 2'b01};
  assign num        = NUM_W'(w_q) * NUM_W'(root_q);
  assign div_try    = {drem_q, dvd_q[Q_W-1]};

  always_comb begin
    q_ext    = $signed({{(SC_W - Q_W){1'b0}}, dvd_q});
    mean_ext = {{(SC_W - MEAN_W){mean_q[MEAN_W-1]}}, mean_q};
    sc_wide  = q_ext - mean_ext - mean_ext;
    if (sc_wide > SAT_HI) begin
      score = {1'b0, {(SCORE_W - 1){1'b1}}};
    end else if (sc_wide < SAT_LO) begin
      score = {1'b1, {(SCORE_W - 1){1'b0}}};
    end else begin
      score = sc_wide[SCORE_W-1:0];
    end
    take       = slot_ok_q && (!have_q || (score > lead_score_q));
    cand_slot  = take ? slot_q : lead_slot_q;
    cand_score = take ? score : lead_score_q;
  end

  assign sts_o.final_item = final_q;
  assign winner_slot_o    = out_slot_q;
  assign winner_score_o   = out_score_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q    <= child_slot_i;
      slot_ok_q <= (int'(child_slot_i) < MAX_CHILDREN);
      mean_q    <= mean_value_i;
      final_q   <= final_child_i;
      w_q       <= W_W'(explore_weight_i) * W_W'(prior_prob_i);
      den_q     <= DEN_W'(child_visits_i[VIS_W-1:0]) + 1'b1;
      rad_q     <= RADP_W'({parent_visits_i[VIS_W-1:0], {RAD_FRAC{1'b0}}});
      rem_q     <= '0;
      root_q    <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q <= {rad_q[RADP_W-3:0], 2'b00};
      if (rem_try >= root_trial) begin
        rem_q  <= rem_try - root_trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_try;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.mul) begin
      dvd_q  <= num[NUM_W-1:FRAC_SHIFT];
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (div_try >= {1'b0, den_q}) begin
        drem_q <= DEN_W'(div_try - {1'b0, den_q});
        dvd_q  <= {dvd_q[Q_W-2:0], 1'b1};
      end else begin
        drem_q <= div_try[DEN_W-1:0];
        dvd_q  <= {dvd_q[Q_W-2:0], 1'b0};
      end
    end
    if (cmd_i.pick && final_q) begin
      out_slot_q  <= cand_slot;
      out_score_q <= cand_score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q       <= 1'b0;
      lead_slot_q  <= '0;
      lead_score_q <= '0;
    end else if (cmd_i.pick) begin
      if (final_q) begin
        have_q       <= 1'b0;
        lead_slot_q  <= '0;
        lead_score_q <= '0;
      end else begin
        have_q       <= have_q || slot_ok_q;
        lead_slot_q  <= cand_slot;
        lead_score_q <= cand_score;
      end
    end
  end

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_step) |-> (drem_q < den_q))
    else $error("divider remainder out of range");

  // root remainder never exceeds twice the partial root
  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.root_step) |-> ({1'b0, rem_q} <= {2'b00, root_q, 1'b0}))
    else $error("root remainder out of range");

  // running best is empty after a selection closes
  a_best_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick && final_q |=> !have_q && (lead_score_q == '0))
    else $error("running best not cleared");

endmodule
